// ===== src/bluray_lpcm_unpacker_assert.svh =====
// Assertion macros shared by the verification code of the LPCM unpacker.
// Depends on nothing; included by the checker file.
`ifndef BLURAY_LPCM_UNPACKER_ASSERT_SVH
`define BLURAY_LPCM_UNPACKER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BLPU_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BLPU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/blpu_pkg.sv =====
// Types, codes and constant tables of the Blu-ray LPCM packet unpacker.
// Depends on nothing; used by the interfaces and all modules.
`default_nettype none

package blpu_pkg;

    // Result kinds.
    localparam logic [2:0] KIND_SAMPLE    = 3'd0;
    localparam logic [2:0] KIND_HDR_OK    = 3'd1;
    localparam logic [2:0] KIND_TOO_SMALL = 3'd2;
    localparam logic [2:0] KIND_BAD_DEPTH = 3'd3;
    localparam logic [2:0] KIND_BAD_RATE  = 3'd4;
    localparam logic [2:0] KIND_BAD_CHAN  = 3'd5;

    // Frame store: one slot per source channel, up to three bytes each.
    localparam int SLOT_COUNT = 8;
    localparam int SLOT_BYTES = 3;
    localparam int SLOT_BITS  = 8 * SLOT_BYTES;

    // Rate codes in the low nibble of header byte 2.
    localparam logic [3:0] RATE_CODE_48K  = 4'd1;
    localparam logic [3:0] RATE_CODE_96K  = 4'd4;
    localparam logic [3:0] RATE_CODE_192K = 4'd5;

    // Depth codes in the top two bits of header byte 3.
    localparam logic [1:0] DEPTH_CODE_16 = 2'd1;
    localparam logic [1:0] DEPTH_CODE_20 = 2'd2;
    localparam logic [1:0] DEPTH_CODE_24 = 2'd3;

    // Layouts whose channels are reordered on output.
    localparam logic [3:0] LAYOUT_5_1 = 4'd9;
    localparam logic [3:0] LAYOUT_7_0 = 4'd10;
    localparam logic [3:0] LAYOUT_7_1 = 4'd11;

    localparam logic [4:0] DEPTH_TABLE [4] = '{5'd0, 5'd16, 5'd20, 5'd24};

    localparam logic [3:0] CHAN_TABLE [16] = '{
        4'd0, 4'd1, 4'd0, 4'd2, 4'd3, 4'd3, 4'd4, 4'd4,
        4'd5, 4'd6, 4'd7, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0
    };

    localparam logic [2:0] ORDER_51 [8] = '{3'd0, 3'd1, 3'd2, 3'd5, 3'd3, 3'd4, 3'd6, 3'd7};
    localparam logic [2:0] ORDER_70 [8] = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd7};
    localparam logic [2:0] ORDER_71 [8] = '{3'd0, 3'd1, 3'd2, 3'd7, 3'd4, 3'd5, 3'd3, 3'd6};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       packet_start;
        logic       packet_last;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         kind;
        logic [2:0]         channel_position;
        logic signed [31:0] sample_value;
        logic               last_in_run;
        logic [3:0]         channel_count;
        logic [17:0]        sample_rate_hz;
        logic [4:0]         bits_per_sample;
        logic [25:0]        stream_rate_bps;
        logic [3:0]         layout_code;
        logic               wide_format;
    } t_out_item;

    // Describes a run of results handed from the parser to the emitter.
    typedef struct packed {
        logic        valid;
        logic        is_header;
        logic [2:0]  kind;
        logic [3:0]  ch;
        logic [17:0] rate;
        logic [4:0]  bits;
        logic [22:0] rate_depth;
        logic [3:0]  layout;
        logic        wide;
    } t_run_load;

    function automatic logic [4:0] depth_bits(input logic [1:0] code);
        return DEPTH_TABLE[code];
    endfunction

    function automatic logic [3:0] layout_channels(input logic [3:0] layout);
        return CHAN_TABLE[layout];
    endfunction

    function automatic logic [17:0] rate_hz(input logic [3:0] code);
        logic [17:0] hz;
        case (code)
            RATE_CODE_48K:  hz = 18'd48000;
            RATE_CODE_96K:  hz = 18'd96000;
            RATE_CODE_192K: hz = 18'd192000;
            default:        hz = 18'd0;
        endcase
        return hz;
    endfunction

    // Sample rate times depth, for the supported codes only.
    function automatic logic [22:0] rate_depth_product(input logic [3:0] rcode,
                                                       input logic [1:0] dcode);
        logic [22:0] prod;
        prod = 23'd0;
        case (rcode)
            RATE_CODE_48K: begin
                case (dcode)
                    DEPTH_CODE_16: prod = 23'd768000;
                    DEPTH_CODE_20: prod = 23'd960000;
                    DEPTH_CODE_24: prod = 23'd1152000;
                    default:       prod = 23'd0;
                endcase
            end
            RATE_CODE_96K: begin
                case (dcode)
                    DEPTH_CODE_16: prod = 23'd1536000;
                    DEPTH_CODE_20: prod = 23'd1920000;
                    DEPTH_CODE_24: prod = 23'd2304000;
                    default:       prod = 23'd0;
                endcase
            end
            RATE_CODE_192K: begin
                case (dcode)
                    DEPTH_CODE_16: prod = 23'd3072000;
                    DEPTH_CODE_20: prod = 23'd3840000;
                    DEPTH_CODE_24: prod = 23'd4608000;
                    default:       prod = 23'd0;
                endcase
            end
            default: prod = 23'd0;
        endcase
        return prod;
    endfunction

    // Source slot that feeds output channel pos for the given layout.
    function automatic logic [2:0] slot_order(input logic [3:0] layout, input logic [2:0] pos);
        logic [2:0] slot;
        case (layout)
            LAYOUT_5_1: slot = ORDER_51[pos];
            LAYOUT_7_0: slot = ORDER_70[pos];
            LAYOUT_7_1: slot = ORDER_71[pos];
            default:    slot = pos;
        endcase
        return slot;
    endfunction

endpackage

`default_nettype wire

// ===== src/blpu_ifs.sv =====
// Valid/ready channel interfaces for packet bytes in and results out.
// Depends on blpu_pkg for the payload types.
`default_nettype none

interface blpu_in_if;
    logic                valid;
    logic                ready;
    blpu_pkg::t_in_item  payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface blpu_out_if;
    logic                valid;
    logic                ready;
    blpu_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/blpu_emitter.sv =====
// Result emitter: holds one run (header result or frame snapshot); drains it, one
// result per cycle unless stalled, into the output register. Depends on blpu_pkg.
`default_nettype none

module blpu_emitter (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire blpu_pkg::t_run_load                    i_load,
    input  wire logic [blpu_pkg::SLOT_COUNT-1:0][blpu_pkg::SLOT_BITS-1:0] i_snap,
    output logic                                        o_can_load,
    blpu_out_if.source                                  o_out
);
    import blpu_pkg::*;

    logic                                 r_run_valid;
    t_run_load                            r_run;
    logic [SLOT_COUNT-1:0][SLOT_BITS-1:0] r_snap;
    logic [2:0]                           r_idx;
    logic                                 r_out_valid;
    t_out_item                            r_out;

    logic                 advance;
    logic                 run_last;
    logic [2:0]           last_idx;
    logic [SLOT_BITS-1:0] word;
    t_out_item            n_out;

    assign last_idx   = 3'(r_run.ch - 4'd1);
    assign advance    = r_run_valid && (!r_out_valid || o_out.ready);
    assign run_last   = r_run.is_header || (r_idx == last_idx);
    assign o_can_load = !r_run_valid || (advance && run_last);

    assign word = r_snap[slot_order(r_run.layout, r_idx)];

    always_comb begin
        n_out                 = '0;
        n_out.kind            = r_run.kind;
        n_out.last_in_run     = run_last;
        n_out.channel_count   = r_run.ch;
        n_out.sample_rate_hz  = r_run.rate;
        n_out.bits_per_sample = r_run.bits;
        n_out.layout_code     = r_run.layout;
        n_out.wide_format     = r_run.wide;
        if (r_run.is_header) begin
            // Error runs carry a zero channel count, so the product is zero there.
            n_out.stream_rate_bps = 26'(r_run.ch) * 26'(r_run.rate_depth);
        end else begin
            n_out.channel_position = r_idx;
            if (r_run.wide) begin
                n_out.sample_value = {word, 8'h00};
            end else begin
                n_out.sample_value = {{16{word[SLOT_BITS-1]}}, word[SLOT_BITS-1 -: 16]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_load.valid) begin
                r_run_valid <= 1'b1;
            end else if (advance && run_last) begin
                r_run_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load.valid) begin
            r_run  <= i_load;
            r_snap <= i_snap;
            r_idx  <= 3'd0;
        end else if (advance) begin
            r_idx <= r_idx + 3'd1;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

`default_nettype wire

// ===== src/bluray_lpcm_unpacker.sv =====
// Top level of the Blu-ray LPCM packet unpacker: header parser and frame store.
// Depends on blpu_pkg, blpu_ifs and blpu_emitter.
//
// Usage:
//   i_in carries one packet byte per transaction, with packet_start on the
//   first byte of a packet and packet_last on the final one. o_out carries
//   results: one info or error result per header, and one sample per coded
//   channel when a source frame completes.
//   The first result caused by a byte enters the emitter's run register
//   when the byte is accepted, then the output register that drives o_out;
//   the samples of one frame follow on consecutive cycles unless o_out
//   stalls. Throughput: one byte per cycle unless stalled. A byte that
//   completes a frame keeps i_in.ready low while the emitter drains its
//   run; a header result costs no stall.
//   The emitter holds one pending run and o_out has its own register, so a
//   new byte is taken while a finished result waits on o_out.
//   When the receiver stalls, o_out holds its transaction, the pending run
//   waits behind it, and i_in.ready drops once a run is pending.
//   Reset (synchronous, active low) returns the parser to waiting for a
//   packet start and empties the emitter; it needs no clearing pass.
`default_nettype none

module bluray_lpcm_unpacker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    blpu_in_if.sink    i_in,
    blpu_out_if.source o_out
);
    import blpu_pkg::*;

    localparam logic [1:0] PHASE_IDLE    = 2'd0;
    localparam logic [1:0] PHASE_HEADER  = 2'd1;
    localparam logic [1:0] PHASE_PAYLOAD = 2'd2;
    localparam logic [1:0] PHASE_SKIP    = 2'd3;

    logic [1:0] r_phase,   n_phase;
    logic [1:0] r_hdr_pos, n_hdr_pos;
    logic [7:0] r_saved,   n_saved;
    logic [2:0] r_slot,    n_slot;
    logic [1:0] r_lane,    n_lane;
    logic [3:0] r_ch,      n_ch;
    logic [3:0] r_layout,  n_layout;
    logic       r_wide,    n_wide;

    logic [SLOT_COUNT-1:0][SLOT_BYTES-1:0][7:0] r_store;
    logic [SLOT_COUNT-1:0][SLOT_BITS-1:0]       snap;

    t_in_item   item;
    t_run_load  load;
    logic       accept;
    logic       can_load;
    logic       wr_en;
    logic [1:0] phase_eff;
    logic [1:0] hdr_pos_eff;
    logic [2:0] slot_eff;
    logic [1:0] lane_eff;
    logic [1:0] wr_elem;
    logic [1:0] last_lane;
    logic [2:0] last_slot;
    logic [4:0] h_bits;
    logic [3:0] h_layout;
    logic [17:0] h_rate;
    logic [3:0] h_ch;

    assign item        = i_in.payload;
    assign i_in.ready  = can_load;
    assign accept      = i_in.valid && can_load;

    assign phase_eff   = item.packet_start ? PHASE_HEADER : r_phase;
    assign hdr_pos_eff = item.packet_start ? 2'd0 : r_hdr_pos;
    assign slot_eff    = item.packet_start ? 3'd0 : r_slot;
    assign lane_eff    = item.packet_start ? 2'd0 : r_lane;

    // The frame holds the channel count rounded up to even.
    assign last_lane = r_wide ? 2'd2 : 2'd1;
    assign last_slot = 3'((r_ch - 4'd1) | 4'd1);
    // Lane 0 is the most significant byte of a slot.
    assign wr_elem   = 2'd2 - lane_eff;

    assign h_bits   = depth_bits(item.data_byte[7:6]);
    assign h_layout = r_saved[7:4];
    assign h_rate   = rate_hz(r_saved[3:0]);
    assign h_ch     = layout_channels(h_layout);

    always_comb begin
        n_phase   = r_phase;
        n_hdr_pos = r_hdr_pos;
        n_saved   = r_saved;
        n_slot    = r_slot;
        n_lane    = r_lane;
        n_ch      = r_ch;
        n_layout  = r_layout;
        n_wide    = r_wide;
        wr_en     = 1'b0;
        load      = '0;
        if (accept) begin
            n_phase   = phase_eff;
            n_hdr_pos = hdr_pos_eff;
            n_slot    = slot_eff;
            n_lane    = lane_eff;
            case (phase_eff)
                PHASE_HEADER: begin
                    if (hdr_pos_eff == 2'd2) begin
                        n_saved = item.data_byte;
                    end
                    if (hdr_pos_eff == 2'd3) begin
                        load.valid     = 1'b1;
                        load.is_header = 1'b1;
                        load.layout    = h_layout;
                        n_slot         = 3'd0;
                        n_lane         = 2'd0;
                        n_phase        = PHASE_SKIP;
                        if (h_bits == 5'd0) begin
                            load.kind = KIND_BAD_DEPTH;
                        end else if (h_rate == 18'd0) begin
                            load.kind = KIND_BAD_RATE;
                            load.bits = h_bits;
                            load.wide = (h_bits != 5'd16);
                        end else if (h_ch == 4'd0) begin
                            load.kind = KIND_BAD_CHAN;
                            load.rate = h_rate;
                            load.bits = h_bits;
                            load.wide = (h_bits != 5'd16);
                        end else begin
                            load.kind       = KIND_HDR_OK;
                            load.ch         = h_ch;
                            load.rate       = h_rate;
                            load.bits       = h_bits;
                            load.rate_depth = rate_depth_product(r_saved[3:0],
                                                                 item.data_byte[7:6]);
                            load.wide       = (h_bits != 5'd16);
                            n_ch            = h_ch;
                            n_layout        = h_layout;
                            n_wide          = (h_bits != 5'd16);
                            n_phase         = PHASE_PAYLOAD;
                        end
                    end else if (item.packet_last) begin
                        load.valid     = 1'b1;
                        load.is_header = 1'b1;
                        load.kind      = KIND_TOO_SMALL;
                    end else begin
                        n_hdr_pos = hdr_pos_eff + 2'd1;
                    end
                end
                PHASE_PAYLOAD: begin
                    wr_en = 1'b1;
                    if (lane_eff == last_lane && slot_eff == last_slot) begin
                        load.valid  = 1'b1;
                        load.kind   = KIND_SAMPLE;
                        load.ch     = r_ch;
                        load.layout = r_layout;
                        load.wide   = r_wide;
                        n_slot      = 3'd0;
                        n_lane      = 2'd0;
                    end else if (lane_eff == last_lane) begin
                        n_slot = slot_eff + 3'd1;
                        n_lane = 2'd0;
                    end else begin
                        n_lane = lane_eff + 2'd1;
                    end
                end
                default: begin
                end
            endcase
            if (item.packet_last) begin
                n_phase   = PHASE_IDLE;
                n_hdr_pos = 2'd0;
                n_slot    = 3'd0;
                n_lane    = 2'd0;
            end
        end
    end

    // Snapshot of the frame including the byte written in this cycle.
    always_comb begin
        for (int s = 0; s < SLOT_COUNT; s++) begin
            for (int e = 0; e < SLOT_BYTES; e++) begin
                if (wr_en && slot_eff == 3'(s) && wr_elem == 2'(e)) begin
                    snap[s][8*e +: 8] = item.data_byte;
                end else begin
                    snap[s][8*e +: 8] = r_store[s][e];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PHASE_IDLE;
            r_hdr_pos <= 2'd0;
            r_saved   <= 8'd0;
            r_slot    <= 3'd0;
            r_lane    <= 2'd0;
            r_ch      <= 4'd0;
            r_layout  <= 4'd0;
            r_wide    <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_pos <= n_hdr_pos;
            r_saved   <= n_saved;
            r_slot    <= n_slot;
            r_lane    <= n_lane;
            r_ch      <= n_ch;
            r_layout  <= n_layout;
            r_wide    <= n_wide;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_store[slot_eff][wr_elem] <= item.data_byte;
        end
    end

    blpu_emitter u_emitter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (load),
        .i_snap     (snap),
        .o_can_load (can_load),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

// ===== src/blpu_checker.sv =====
// Port-level checker for the LPCM unpacker, bound to its top level.
// Depends on blpu_pkg and the assertion macro header.
`default_nettype none
`include "bluray_lpcm_unpacker_assert.svh"

module blpu_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_out_valid,
    input wire logic                i_out_ready,
    input wire blpu_pkg::t_out_item i_out_payload
);
    import blpu_pkg::*;

    logic stalled;
    logic is_sample;

    assign stalled   = i_out_valid && !i_out_ready;
    assign is_sample = i_out_valid && (i_out_payload.kind == KIND_SAMPLE);

    `BLPU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled, i_out_valid, "result dropped while stalled")
    `BLPU_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, stalled, $stable(i_out_payload), "stalled result changed")
    `BLPU_ASSERT_IMP(a_hdr_single, i_clk, i_rst_n, i_out_valid && !is_sample, i_out_payload.last_in_run, "header result not last in run")
    `BLPU_ASSERT_IMP(a_pos_range, i_clk, i_rst_n, is_sample, 4'(i_out_payload.channel_position) < i_out_payload.channel_count, "sample position beyond channel count")
    `BLPU_ASSERT_IMP(a_run_end, i_clk, i_rst_n, is_sample, i_out_payload.last_in_run == (4'(i_out_payload.channel_position) + 4'd1 == i_out_payload.channel_count), "last flag off the final channel")

endmodule

bind bluray_lpcm_unpacker blpu_checker u_blpu_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

`default_nettype wire
